// ----- rtl/cdt_pkg.sv -----
// shared constants and codes for the countdown timer with pause
`timescale 1ns / 1ps
`default_nettype none

package cdt_pkg;

	localparam int TIME_BITS = 16;
	localparam int STEP_W    = 12;
	localparam int PHASE_W   = 8;
	localparam int OP_W      = 3;
	localparam int MODE_W    = 3;
	localparam int STATUS_W  = 2;
	localparam int REM_OUT_W = 16;
	localparam int TOTAL_W   = 32;
	localparam int CFG_IDX_W = 2;

	// width of the set-mode add and compare
	localparam int SUM_W     = ((TIME_BITS > STEP_W) ? TIME_BITS : STEP_W) + 1;
	// width that holds either the remaining time or the remaining field, whichever is wider
	localparam int REM_EXT_W = (TIME_BITS > REM_OUT_W) ? TIME_BITS : REM_OUT_W;

	localparam logic [MODE_W-1:0] MODE_IDLE   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_SET    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_COUNT  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_PAUSED = 3'd3;
	localparam logic [MODE_W-1:0] MODE_TOTAL  = 3'd4;

	localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
	localparam logic [OP_W-1:0] OP_INC   = 3'd1;
	localparam logic [OP_W-1:0] OP_DEC   = 3'd2;
	localparam logic [OP_W-1:0] OP_START = 3'd3;
	localparam logic [OP_W-1:0] OP_ABORT = 3'd4;

	localparam logic [STATUS_W-1:0] ST_HANDLED = 2'd0;
	localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_TRANS   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_SET_STEP       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_MATCH     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BEEP_THRESHOLD = 2'd2;

	localparam logic [STEP_W-1:0]  SET_STEP_RESET       = 12'd60;
	localparam logic [PHASE_W-1:0] TICK_MATCH_RESET     = 8'd10;
	localparam logic [PHASE_W-1:0] BEEP_THRESHOLD_RESET = 8'd5;

	localparam logic [TIME_BITS-1:0] TIME_MAX  = {TIME_BITS{1'b1}};
	localparam logic [TOTAL_W-1:0]   TOTAL_MAX = {TOTAL_W{1'b1}};

endpackage

`default_nettype wire

// ----- rtl/countdown_timer_with_pause.sv -----
// top level of the countdown timer with pause: mode state, time counters, result register
`timescale 1ns / 1ps
`default_nettype none

// Each accepted event is applied to the mode and time registers in the cycle it is
// transferred, and its result appears in the output register on the next cycle.
// One event can be taken every clock cycle: in_ready is high whenever the output
// register is empty or its result is being taken in the same cycle, so the rate is
// one event per cycle, held back only by the single result
// register. Configuration writes are always accepted (cfg_ready is tied high) and
// a write to index 3 does nothing.
module countdown_timer_with_pause
	import cdt_pkg::*;
(
	input  wire                      clk,
	input  wire                      arst_n,

	input  wire                      cfg_valid,
	output logic                     cfg_ready,
	input  wire  [CFG_IDX_W-1:0]     cfg_index,
	input  wire  [STEP_W-1:0]        cfg_data,

	input  wire                      in_valid,
	output logic                     in_ready,
	input  wire  [OP_W-1:0]          op,
	input  wire  [PHASE_W-1:0]       tick_phase,

	output logic                     out_valid,
	input  wire                      out_ready,
	output logic [STATUS_W-1:0]      status,
	output logic [MODE_W-1:0]        mode,
	output logic [REM_OUT_W-1:0]     remaining,
	output logic [TOTAL_W-1:0]       total,
	output logic                     beep
);

	logic [STEP_W-1:0]    set_step_q;
	logic [PHASE_W-1:0]   tick_match_q;
	logic [PHASE_W-1:0]   beep_threshold_q;

	logic [MODE_W-1:0]    mode_q;
	logic [TIME_BITS-1:0] remaining_q;
	logic [TIME_BITS-1:0] elapsed_q;
	logic [TOTAL_W-1:0]   total_q;

	logic                 out_valid_q;
	logic [STATUS_W-1:0]  status_q;
	logic [MODE_W-1:0]    mode_out_q;
	logic [REM_OUT_W-1:0] remaining_out_q;
	logic [TOTAL_W-1:0]   total_out_q;
	logic                 beep_q;

	logic                 in_xfer;
	logic                 cfg_xfer;

	logic [MODE_W-1:0]    mode_d;
	logic [TIME_BITS-1:0] remaining_d;
	logic [TIME_BITS-1:0] elapsed_d;
	logic [TOTAL_W-1:0]   total_d;
	logic [STATUS_W-1:0]  status_d;
	logic                 beep_d;
	logic [REM_EXT_W-1:0] remaining_ext;

	assign cfg_ready = 1'b1;
	assign cfg_xfer  = cfg_valid & cfg_ready;
	assign in_ready  = ~out_valid_q | out_ready;
	assign in_xfer   = in_valid & in_ready;

	always_comb begin
		logic [SUM_W-1:0]     rem_ext;
		logic [SUM_W-1:0]     step_ext;
		logic [SUM_W-1:0]     inc_sum;
		logic [TIME_BITS-1:0] el_tmp;
		logic [TOTAL_W:0]     fold_sum;
		logic                 phase_hit;

		rem_ext     = SUM_W'(remaining_q);
		step_ext    = SUM_W'(set_step_q);
		inc_sum     = rem_ext + step_ext;
		phase_hit   = (op == OP_TICK) && (tick_phase == tick_match_q);
		mode_d      = mode_q;
		remaining_d = remaining_q;
		el_tmp      = elapsed_q;
		status_d    = ST_IGNORED;
		beep_d      = 1'b0;

		case (mode_q)
			MODE_IDLE: begin
				if (op == OP_TICK) begin
					if (tick_phase >= beep_threshold_q) begin
						beep_d   = 1'b1;
						status_d = ST_HANDLED;
					end
				end else if (op inside {OP_INC, OP_DEC}) begin
					mode_d   = MODE_SET;
					status_d = ST_TRANS;
				end else if (op == OP_START) begin
					mode_d   = MODE_TOTAL;
					status_d = ST_TRANS;
				end
			end
			MODE_SET: begin
				if (op == OP_INC) begin
					if (inc_sum > SUM_W'(TIME_MAX)) begin
						remaining_d = TIME_MAX;
					end else begin
						remaining_d = inc_sum[TIME_BITS-1:0];
					end
					status_d = ST_HANDLED;
				end else if (op == OP_DEC) begin
					if (rem_ext >= step_ext) begin
						remaining_d = remaining_q - TIME_BITS'(set_step_q);
						status_d    = ST_HANDLED;
					end
				end else if (op == OP_ABORT) begin
					mode_d   = MODE_IDLE;
					status_d = ST_TRANS;
				end else if (op == OP_START) begin
					mode_d   = MODE_COUNT;
					status_d = ST_TRANS;
				end
			end
			MODE_COUNT: begin
				if (op == OP_START) begin
					mode_d   = MODE_PAUSED;
					status_d = ST_TRANS;
				end else if (phase_hit) begin
					if (remaining_q == '0) begin
						mode_d   = MODE_IDLE;
						status_d = ST_TRANS;
					end else begin
						remaining_d = remaining_q - TIME_BITS'(1);
						if (elapsed_q != TIME_MAX) begin
							el_tmp = elapsed_q + TIME_BITS'(1);
						end
						if (remaining_q == TIME_BITS'(1)) begin
							mode_d   = MODE_IDLE;
							status_d = ST_TRANS;
						end else begin
							status_d = ST_HANDLED;
						end
					end
				end
			end
			MODE_PAUSED: begin
				if (op inside {OP_INC, OP_DEC}) begin
					mode_d   = MODE_SET;
					status_d = ST_TRANS;
				end else if (op == OP_START) begin
					mode_d   = MODE_COUNT;
					status_d = ST_TRANS;
				end else if (op == OP_ABORT) begin
					mode_d   = MODE_IDLE;
					status_d = ST_TRANS;
				end
			end
			MODE_TOTAL: begin
				if (phase_hit) begin
					mode_d   = MODE_IDLE;
					status_d = ST_TRANS;
				end
			end
			default: begin
				mode_d = mode_q;
			end
		endcase

		// leaving count folds elapsed time into the total
		fold_sum = {1'b0, total_q} + (TOTAL_W + 1)'(el_tmp);
		if ((mode_q == MODE_COUNT) && (mode_d != MODE_COUNT)) begin
			elapsed_d = '0;
			if (fold_sum[TOTAL_W]) begin
				total_d = TOTAL_MAX;
			end else begin
				total_d = fold_sum[TOTAL_W-1:0];
			end
		end else begin
			elapsed_d = el_tmp;
			total_d   = total_q;
		end
	end

	assign remaining_ext = REM_EXT_W'(remaining_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_step_q       <= SET_STEP_RESET;
			tick_match_q     <= TICK_MATCH_RESET;
			beep_threshold_q <= BEEP_THRESHOLD_RESET;
		end else if (cfg_xfer) begin
			case (cfg_index)
				REG_SET_STEP:       set_step_q       <= cfg_data;
				REG_TICK_MATCH:     tick_match_q     <= cfg_data[PHASE_W-1:0];
				REG_BEEP_THRESHOLD: beep_threshold_q <= cfg_data[PHASE_W-1:0];
				default:            set_step_q       <= set_step_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			remaining_q <= '0;
			elapsed_q   <= '0;
			total_q     <= '0;
		end else if (in_xfer) begin
			mode_q      <= mode_d;
			remaining_q <= remaining_d;
			elapsed_q   <= elapsed_d;
			total_q     <= total_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			status_q        <= status_d;
			mode_out_q      <= mode_d;
			remaining_out_q <= remaining_ext[REM_OUT_W-1:0];
			total_out_q     <= total_d;
			beep_q          <= beep_d;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign mode      = mode_out_q;
	assign remaining = remaining_out_q;
	assign total     = total_out_q;
	assign beep      = beep_q;

	// elapsed time only builds up while counting
	a_elapsed_only_in_count: assert property (@(posedge clk) disable iff (!arst_n)
		(elapsed_q != '0) |-> (mode_q == MODE_COUNT))
		else $error("elapsed time held outside count mode");

	// beep only on a handled idle tick
	a_beep_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && beep_q) |-> ((mode_out_q == MODE_IDLE) && (status_q == ST_HANDLED)))
		else $error("beep flagged outside a handled idle tick");

	// a matching tick in total display returns to idle
	a_total_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && (mode_q == MODE_TOTAL) && (op == OP_TICK) && (tick_phase == tick_match_q))
		|=> (mode_q == MODE_IDLE))
		else $error("total display did not return to idle");

	// result register mirrors the mode state after each transfer
	a_mode_mirror: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (out_valid_q && (mode_out_q == mode_q)))
		else $error("result mode differs from mode state");

endmodule

`default_nettype wire

// ----- tb/tb_countdown_timer_with_pause.sv -----
// self-checking testbench for the countdown timer with pause: directed and random events against a predictor
`timescale 1ns / 1ps

module tb_countdown_timer_with_pause;
	import cdt_pkg::*;

	localparam int DIRECTED_ITEMS = 25;
	localparam int RANDOM_ITEMS   = 850;
	localparam int ITEMS_PER_SET  = 110;
	localparam int CALM_TAIL      = 120;
	localparam int MAX_PRINTED    = 40;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef enum logic [1:0] {ACT_EVENT, ACT_WRITE, ACT_DRAIN} act_kind_t;

	typedef struct packed {
		act_kind_t            kind;
		logic [OP_W-1:0]      op;
		logic [PHASE_W-1:0]   phase;
		logic [CFG_IDX_W-1:0] idx;
		logic [STEP_W-1:0]    data;
	} action_t;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [MODE_W-1:0]    mode;
		logic [REM_OUT_W-1:0] remaining;
		logic [TOTAL_W-1:0]   total;
		logic                 beep;
	} timer_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [STEP_W-1:0]    cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [OP_W-1:0]      op;
	logic [PHASE_W-1:0]   tick_phase;
	logic                 out_valid;
	logic                 out_ready;
	logic [STATUS_W-1:0]  status;
	logic [MODE_W-1:0]    mode;
	logic [REM_OUT_W-1:0] remaining;
	logic [TOTAL_W-1:0]   total;
	logic                 beep;

	countdown_timer_with_pause dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.tick_phase (tick_phase),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.mode       (mode),
		.remaining  (remaining),
		.total      (total),
		.beep       (beep)
	);

	action_t       planned[$];
	timer_result_t results_due[$];

	int n_events       = 0;
	int ev_sent        = 0;
	int ev_taken       = 0;
	int cfg_sent       = 0;
	int cfg_taken      = 0;
	int gap_left       = 0;
	int settle_left    = 0;
	int stall_left     = 0;
	int mismatch_count = 0;

	// predictor state
	logic [STEP_W-1:0]    step_r        = SET_STEP_RESET;
	logic [PHASE_W-1:0]   match_r       = TICK_MATCH_RESET;
	logic [PHASE_W-1:0]   thr_r         = BEEP_THRESHOLD_RESET;
	logic [MODE_W-1:0]    cur_mode      = MODE_IDLE;
	logic [TIME_BITS-1:0] cur_remaining = '0;
	logic [TIME_BITS-1:0] cur_elapsed   = '0;
	logic [TOTAL_W-1:0]   cur_total     = '0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(5_000_000);
		$display("Mismatches found");
		$finish;
	end

	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTED)
			$display("%0t: %s: got %0h, expected %0h", $realtime, what, got, want);
	endtask

	function automatic logic [STATUS_W-1:0] enter_mode(input logic [MODE_W-1:0] nxt);
		logic [TOTAL_W:0] sum;
		// leaving count mode folds elapsed time into the total
		if (cur_mode == MODE_COUNT && nxt != MODE_COUNT) begin
			sum = {1'b0, cur_total} + (TOTAL_W + 1)'(cur_elapsed);
			cur_total = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
			cur_elapsed = '0;
		end
		cur_mode = nxt;
		return ST_TRANS;
	endfunction

	task automatic advance_timer(input logic [OP_W-1:0] o, input logic [PHASE_W-1:0] ph,
			output timer_result_t r);
		logic [STATUS_W-1:0] st;
		logic                bp;
		logic [SUM_W-1:0]    sum;
		st = ST_IGNORED;
		bp = 1'b0;
		case (cur_mode)
		MODE_IDLE: begin
			if (o == OP_TICK) begin
				if (ph >= thr_r) begin
					bp = 1'b1;
					st = ST_HANDLED;
				end
			end else if (o == OP_INC || o == OP_DEC) begin
				st = enter_mode(MODE_SET);
			end else if (o == OP_START) begin
				st = enter_mode(MODE_TOTAL);
			end
		end
		MODE_SET: begin
			if (o == OP_INC) begin
				sum = SUM_W'(cur_remaining) + SUM_W'(step_r);
				cur_remaining = (sum > SUM_W'(TIME_MAX)) ? TIME_MAX : sum[TIME_BITS-1:0];
				st = ST_HANDLED;
			end else if (o == OP_DEC) begin
				if (cur_remaining >= TIME_BITS'(step_r)) begin
					cur_remaining = cur_remaining - TIME_BITS'(step_r);
					st = ST_HANDLED;
				end
			end else if (o == OP_ABORT) begin
				st = enter_mode(MODE_IDLE);
			end else if (o == OP_START) begin
				st = enter_mode(MODE_COUNT);
			end
		end
		MODE_COUNT: begin
			if (o == OP_START) begin
				st = enter_mode(MODE_PAUSED);
			end else if (o == OP_TICK && ph == match_r) begin
				if (cur_remaining == '0) begin
					st = enter_mode(MODE_IDLE);
				end else begin
					cur_remaining = cur_remaining - TIME_BITS'(1);
					if (cur_elapsed != TIME_MAX)
						cur_elapsed = cur_elapsed + TIME_BITS'(1);
					if (cur_remaining == '0)
						st = enter_mode(MODE_IDLE);
					else
						st = ST_HANDLED;
				end
			end
		end
		MODE_PAUSED: begin
			if (o == OP_INC || o == OP_DEC)
				st = enter_mode(MODE_SET);
			else if (o == OP_START)
				st = enter_mode(MODE_COUNT);
			else if (o == OP_ABORT)
				st = enter_mode(MODE_IDLE);
		end
		MODE_TOTAL: begin
			if (o == OP_TICK && ph == match_r)
				st = enter_mode(MODE_IDLE);
		end
		default: begin
		end
		endcase
		r.status    = st;
		r.mode      = cur_mode;
		r.remaining = REM_OUT_W'(cur_remaining);
		r.total     = cur_total;
		r.beep      = bp;
	endtask

	task automatic plan_event(input logic [OP_W-1:0] o, input logic [PHASE_W-1:0] ph);
		action_t a;
		a = '0;
		a.kind  = ACT_EVENT;
		a.op    = o;
		a.phase = ph;
		planned.push_back(a);
		n_events++;
	endtask

	task automatic plan_write(input logic [CFG_IDX_W-1:0] idx, input logic [STEP_W-1:0] data);
		action_t a;
		a = '0;
		a.kind = ACT_WRITE;
		a.idx  = idx;
		a.data = data;
		planned.push_back(a);
	endtask

	task automatic plan_settings(input logic [STEP_W-1:0] s, input logic [PHASE_W-1:0] m,
			input logic [PHASE_W-1:0] t);
		action_t a;
		// sender holds off until every result is back
		a = '0;
		a.kind = ACT_DRAIN;
		planned.push_back(a);
		plan_write(REG_SET_STEP, s);
		plan_write(REG_TICK_MATCH, STEP_W'(m));
		plan_write(REG_BEEP_THRESHOLD, STEP_W'(t));
	endtask

	// set a time, run it down mostly with matching ticks, then end with start, abort and a matching tick
	task automatic plan_session(input int step, input logic [PHASE_W-1:0] m);
		int k;
		int n;
		k = $urandom_range(0, 4);
		if (k == 0)
			plan_event(OP_DEC, PHASE_W'($urandom_range(0, 255)));
		repeat (k) plan_event(OP_INC, PHASE_W'($urandom_range(0, 255)));
		if ($urandom_range(0, 3) == 0)
			plan_event(OP_DEC, PHASE_W'($urandom_range(0, 255)));
		plan_event(OP_START, PHASE_W'($urandom_range(0, 255)));
		n = (step * k <= 30) ? step * k + 2 : $urandom_range(3, 30);
		repeat (n) begin
			case ($urandom_range(0, 19))
			0: begin
				plan_event(OP_START, PHASE_W'($urandom_range(0, 255)));
				plan_event(OP_START, PHASE_W'($urandom_range(0, 255)));
			end
			1: plan_event(OP_W'($urandom_range(0, 7)), PHASE_W'($urandom_range(0, 255)));
			2, 3: plan_event(OP_TICK, PHASE_W'($urandom_range(0, 255)));
			default: plan_event(OP_TICK, m);
			endcase
		end
		plan_event(OP_START, PHASE_W'($urandom_range(0, 255)));
		plan_event(OP_ABORT, PHASE_W'($urandom_range(0, 255)));
		plan_event(OP_TICK, m);
	endtask

	// sender
	always @(negedge clk) begin : drive_inputs
		action_t a;
		logic    iv;
		logic    cv;
		if (arst_n) begin
			iv = in_valid && (ev_sent != ev_taken);
			cv = cfg_valid && (cfg_sent != cfg_taken);
			if (!iv && !cv) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (settle_left > 0) begin
					settle_left--;
				end else if (planned.size() > 0) begin
					a = planned[0];
					case (a.kind)
					ACT_EVENT: begin
						if (planned.size() > CALM_TAIL && $urandom_range(0, 9) == 0) begin
							gap_left = $urandom_range(0, 8);
						end else begin
							void'(planned.pop_front());
							op         <= a.op;
							tick_phase <= a.phase;
							iv = 1'b1;
							ev_sent++;
						end
					end
					ACT_WRITE: begin
						if (results_due.size() == 0) begin
							void'(planned.pop_front());
							cfg_index <= a.idx;
							cfg_data  <= a.data;
							cv = 1'b1;
							cfg_sent++;
						end
					end
					default: begin
						if (results_due.size() == 0) begin
							void'(planned.pop_front());
							settle_left = 2;
						end
					end
					endcase
				end
			end
			in_valid  <= iv;
			cfg_valid <= cv;
		end
	end

	// receiver
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (planned.size() > CALM_TAIL && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(0, 8);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : watch_outputs
		timer_result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (results_due.size() == 0) begin
					report_mismatch("result with none due", status, 0);
				end else begin
					want = results_due.pop_front();
					if (status !== want.status)
						report_mismatch("status", status, want.status);
					if (mode !== want.mode)
						report_mismatch("mode", mode, want.mode);
					if (remaining !== want.remaining)
						report_mismatch("remaining", remaining, want.remaining);
					if (total !== want.total)
						report_mismatch("total", total, want.total);
					if (beep !== want.beep)
						report_mismatch("beep", beep, want.beep);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				REG_SET_STEP:       step_r  = cfg_data;
				REG_TICK_MATCH:     match_r = cfg_data[PHASE_W-1:0];
				REG_BEEP_THRESHOLD: thr_r   = cfg_data[PHASE_W-1:0];
				default: begin
				end
				endcase
				cfg_taken++;
			end
			if (in_valid && in_ready) begin
				advance_timer(op, tick_phase, want);
				results_due.push_back(want);
				ev_taken++;
			end
		end
	end

	initial begin : stimulus
		int                 round;
		int                 next_switch;
		int                 gen_step;
		logic [STEP_W-1:0]  s;
		logic [PHASE_W-1:0] m;
		logic [PHASE_W-1:0] t;

		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		in_valid   = 1'b0;
		op         = '0;
		tick_phase = '0;
		out_ready  = 1'b0;

		// directed, reset settings: step 60, match 10, threshold 5
		plan_event(OP_TICK, 8'd0);
		plan_event(OP_TICK, 8'd4);
		plan_event(OP_TICK, 8'd5);
		plan_event(OP_TICK, 8'd255);
		plan_event(3'd7, 8'd0);
		plan_event(OP_DEC, 8'd0);
		plan_event(OP_DEC, 8'd0);
		plan_event(OP_START, 8'd0);
		plan_event(OP_TICK, 8'd10);
		plan_event(OP_INC, 8'd0);
		plan_event(OP_INC, 8'd0);
		plan_event(OP_INC, 8'd0);
		plan_event(OP_DEC, 8'd0);
		plan_event(OP_START, 8'd0);
		plan_event(OP_TICK, 8'd9);
		plan_event(OP_TICK, 8'd10);
		plan_event(OP_ABORT, 8'd0);
		plan_event(OP_START, 8'd0);
		plan_event(3'd5, 8'd0);
		plan_event(OP_START, 8'd0);
		plan_event(OP_START, 8'd0);
		plan_event(OP_INC, 8'd0);
		plan_event(OP_ABORT, 8'd0);
		plan_event(OP_START, 8'd0);
		plan_event(OP_TICK, 8'd10);

		round       = 0;
		next_switch = n_events;
		gen_step    = SET_STEP_RESET;
		m           = TICK_MATCH_RESET;
		while (n_events < DIRECTED_ITEMS + RANDOM_ITEMS) begin
			if (n_events >= next_switch) begin
				t = PHASE_W'($urandom_range(0, 255));
				case (round)
				0: begin
					s = 12'd1;
					m = 8'd0;
					t = 8'd0;
				end
				1: begin
					s = 12'd4095;
					m = 8'd255;
					t = 8'd255;
				end
				2: begin
					s = 12'd0;
					m = PHASE_W'($urandom_range(0, 255));
					plan_write(REG_UNUSED, STEP_W'($urandom_range(0, 4095)));
				end
				3: begin
					s = 12'd3600;
					m = PHASE_W'($urandom_range(0, 255));
				end
				4: begin
					s = SET_STEP_RESET;
					m = TICK_MATCH_RESET;
					t = BEEP_THRESHOLD_RESET;
				end
				default: begin
					s = ($urandom_range(0, 2) != 0) ? STEP_W'($urandom_range(0, 8))
						: STEP_W'($urandom_range(0, 4095));
					m = PHASE_W'($urandom_range(0, 255));
				end
				endcase
				plan_settings(s, m, t);
				gen_step    = s;
				round++;
				next_switch = n_events + ITEMS_PER_SET;
			end
			if ($urandom_range(0, 3) != 0)
				plan_session(gen_step, m);
			else
				repeat ($urandom_range(1, 6))
					plan_event(OP_W'($urandom_range(0, 7)), PHASE_W'($urandom_range(0, 255)));
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (planned.size() != 0 || in_valid || cfg_valid || results_due.size() != 0)
			@(negedge clk);
		repeat (5) @(negedge clk);
		if (results_due.size() != 0)
			report_mismatch("results never delivered", results_due.size(), 0);

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/cdt_pkg.sv
rtl/countdown_timer_with_pause.sv
tb/tb_countdown_timer_with_pause.sv
